// ----- src/sal_pkg.sv -----
// ----------------------------------------------------------------------------
// sal_pkg
// Shared types and constants of the shifting array list engine.
// ----------------------------------------------------------------------------
package sal_pkg;

   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int POS_W   = 4;
   localparam int OP_W    = 3;
   localparam int ST_W    = 2;
   localparam int WORD_W  = 32;
   localparam int CAP_W   = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // operation codes
   localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_EDIT   = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
   localparam logic [OP_W-1:0] OP_GET    = 3'd4;

   // result status codes
   localparam logic [ST_W-1:0] STAT_DONE   = 2'd0;
   localparam logic [ST_W-1:0] STAT_FULL   = 2'd1;
   localparam logic [ST_W-1:0] STAT_BADPOS = 2'd2;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch the request payload
      logic execute;   // perform the operation and load the result register
   } dp_cmd_type;

endpackage

// ----- src/sal_ctrl.sv -----
// ----------------------------------------------------------------------------
// sal_ctrl
// Sequencer: takes a request, fires the datapath once and owns the result
// valid flag.
// ----------------------------------------------------------------------------
module sal_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sal_pkg::dp_cmd_type cmd
);
   import sal_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // wait until the result register is free or being emptied
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_exec_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid_ff)
      else $error("result not presented after execute");
   a_capture_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_EXEC) && !req_ready)
      else $error("request taken while busy");
`endif

endmodule

// ----- src/sal_dpath.sv -----
// ----------------------------------------------------------------------------
// sal_dpath
// Row of entry cells with shift, count, capacity register and
// result register.
// ----------------------------------------------------------------------------
module sal_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  sal_pkg::dp_cmd_type                 cmd,
   input  logic [sal_pkg::OP_W-1:0]            req_op,
   input  logic [sal_pkg::POS_W-1:0]           req_position,
   input  logic signed [sal_pkg::WORD_W-1:0]   req_value,
   input  logic                                csr_write,
   input  logic [sal_pkg::CAP_W-1:0]           csr_capacity,
   output logic [sal_pkg::ST_W-1:0]            rsp_status,
   output logic signed [sal_pkg::WORD_W-1:0]   rsp_read_value,
   output logic [sal_pkg::CNT_W-1:0]           rsp_entry_count,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full
);
   import sal_pkg::*;

   logic [OP_W-1:0]          op_ff;
   logic [POS_W-1:0]         pos_ff;
   logic signed [WORD_W-1:0] val_ff;
   logic [CAP_W-1:0]         cap_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [WORD_W-1:0] entries_ff [DEPTH];
   logic signed [WORD_W-1:0] entries_in [DEPTH];

   logic [ST_W-1:0]          status_ff, status_in;
   logic signed [WORD_W-1:0] rdval_ff, rdval_in;
   logic [CNT_W-1:0]         rcount_ff;
   logic                     empty_ff, full_ff, full_in;

   logic [CNT_W-1:0] eff_cap, pos_ext;
   logic             full_now, op_ok;

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_op;
         pos_ff <= req_position;
         val_ff <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         count_ff <= '0;
      end else begin
         if (csr_write)
            cap_ff <= csr_capacity;
         if (cmd.execute)
            count_ff <= count_in;
      end
   end

   assign eff_cap  = (CNT_W'(cap_ff) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_ff);
   assign full_now = count_ff >= eff_cap;
   assign pos_ext  = CNT_W'(pos_ff);

   always_comb begin
      status_in = STAT_DONE;
      rdval_in  = '0;
      count_in  = count_ff;
      op_ok     = 1'b0;
      case (op_ff)
         OP_APPEND: begin
            if (full_now) status_in = STAT_FULL;
            else begin
               op_ok    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_INSERT: begin
            // full check takes priority over a bad position
            if (full_now) status_in = STAT_FULL;
            else if (pos_ext > count_ff) status_in = STAT_BADPOS;
            else begin
               op_ok    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_EDIT: begin
            if (pos_ext >= count_ff) status_in = STAT_BADPOS;
            else op_ok = 1'b1;
         end
         OP_DELETE: begin
            if (pos_ext >= count_ff) status_in = STAT_BADPOS;
            else begin
               op_ok    = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         OP_GET: begin
            if (pos_ext >= count_ff) begin
               status_in = STAT_BADPOS;
               rdval_in  = '1;
            end else begin
               rdval_in = entries_ff[pos_ff];
            end
         end
         default: ;
      endcase
      full_in = count_in >= eff_cap;
   end

   // entry cells: each takes its own word, a neighbour or the new value
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [WORD_W-1:0] lower, upper;
      logic [CNT_W-1:0]         idx, idx_up;

      if (g > 0) begin : g_lo
         assign lower = entries_ff[g-1];
      end else begin : g_lo0
         assign lower = val_ff;
      end
      if (g < DEPTH - 1) begin : g_hi
         assign upper = entries_ff[g+1];
      end else begin : g_hi0
         assign upper = entries_ff[g];
      end

      assign idx    = CNT_W'(g);
      assign idx_up = CNT_W'(g + 1);

      always_comb begin
         entries_in[g] = entries_ff[g];
         if (op_ok) begin
            case (op_ff)
               OP_APPEND: if (idx == count_ff) entries_in[g] = val_ff;
               OP_INSERT: begin
                  if (idx == pos_ext) entries_in[g] = val_ff;
                  else if (idx > pos_ext && idx <= count_ff) entries_in[g] = lower;
               end
               OP_EDIT:   if (idx == pos_ext) entries_in[g] = val_ff;
               OP_DELETE: if (idx >= pos_ext && idx_up < count_ff) entries_in[g] = upper;
               default: ;
            endcase
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.execute)
            entries_ff[g] <= entries_in[g];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         rdval_ff  <= rdval_in;
         rcount_ff <= count_in;
         empty_ff  <= (count_in == '0);
         full_ff   <= full_in;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_read_value  = rdval_ff;
   assign rsp_entry_count = rcount_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_is_full     = full_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");
   a_count_quiet: assert property (@(posedge clock) disable iff (reset)
      !cmd.execute |=> $stable(count_ff))
      else $error("count moved without an operation");
   a_result_count: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> (rcount_ff == count_ff) && (empty_ff == (count_ff == '0)))
      else $error("reported count differs from stored count");
`endif

endmodule

// ----- src/shifting_array_list_engine.sv -----
// ----------------------------------------------------------------------------
// shifting_array_list_engine
// Packed ordered list of signed words with append, insert, edit, delete, get.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  req      | in        | req_valid / req_ready  | op, position, value
//  rsp      | out       | rsp_valid / rsp_ready  | status, read_value, entry_count,
//           |           |                        | is_empty, is_full
//  csr      | in        | csr_valid / csr_ready  | capacity (always ready)
//
//  Each transaction has a capture step, then an execute step in which the row
//  of entry cells shifts or is written in full and the result register loads.
//  The result register lets the next transaction be taken while a result waits;
//  the execute cycle stalls only while that register is still occupied.
//  Synchronous reset empties the list and sets capacity to 16; entry contents
//  are not cleared.
// ----------------------------------------------------------------------------
module shifting_array_list_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sal_pkg::OP_W-1:0]            req_op,
   input  logic [sal_pkg::POS_W-1:0]           req_position,
   input  logic signed [sal_pkg::WORD_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sal_pkg::ST_W-1:0]            rsp_status,
   output logic signed [sal_pkg::WORD_W-1:0]   rsp_read_value,
   output logic [sal_pkg::CNT_W-1:0]           rsp_entry_count,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sal_pkg::CAP_W-1:0]           csr_capacity
);
   import sal_pkg::*;

   dp_cmd_type cmd;

   assign csr_ready = 1'b1;

   sal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sal_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (req_op),
      .req_position    (req_position),
      .req_value       (req_value),
      .csr_write       (csr_valid),
      .csr_capacity    (csr_capacity),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

endmodule
